/* sv/epoch_seconds_to_calendar_top_defines.svh */
// assertion helpers shared by the converter modules
// each one expects clk and rst_n to be visible where it is used
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// same-cycle implication
`define ESC_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/esc_pkg.sv */
`default_nettype none

package esc_pkg;

  localparam int NUM_STG = 7;

  // days = (t >> 7) / 675, exact for 25-bit operands
  localparam logic [25:0] DAY_MUL   = 26'd50903317;
  localparam int          DAY_SHIFT = 35;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  // day counting from 1968-01-01, first year of a four-year cycle
  localparam logic [15:0] EPOCH_OFS     = 16'd731;
  // 2100-03-01; from here a phantom leap day keeps the cycles regular
  localparam logic [15:0] LEAP_SKIP_DAY = 16'd48272;
  localparam logic [5:0]  SKIP_CYCLE    = 6'd33;
  localparam logic [16:0] CYC_MUL       = 17'd91868;
  localparam int          CYC_SHIFT     = 27;
  localparam logic [10:0] CYC_DAYS      = 11'd1461;
  localparam logic [7:0]  YEAR_BASE     = 8'd68;

  // weekday: (days + 4) mod 7
  localparam logic [15:0] WD_OFS   = 16'd4;
  localparam logic [16:0] WD_MUL   = 17'd74899;
  localparam int          WD_SHIFT = 19;

  // time of day
  localparam logic [13:0] HR_MUL    = 14'd9321;
  localparam int          HR_SHIFT  = 21;
  localparam logic [11:0] SEC_PER_HR = 12'd3600;
  localparam logic [10:0] MIN_MUL   = 11'd1093;
  localparam int          MIN_SHIFT = 14;
  localparam logic [11:0] SEC_PER_MIN = 12'd60;

  localparam logic [3:0] MONTH_MAR = 4'd2;

  typedef struct packed {
    logic [NUM_STG-1:0] load;
    logic [NUM_STG-1:0] valid;
  } esc_ctl_t;

  // first day of year index of month m (0 is january)
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    base = 9'd0;
    case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m >= MONTH_MAR)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

`default_nettype wire

/* sv/esc_split.sv */
`default_nettype none

module esc_split
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire esc_ctl_t    ctl,
  input  wire logic [31:0] t,
  output logic [16:0]      secs,
  output logic [15:0]      dnum,
  output logic             after_skip,
  output logic [15:0]      wd_x,
  output logic [13:0]      wd_q
);

  logic [31:0] t1_r;
  logic [15:0] days1_r;
  logic [50:0] day_prod;
  logic [15:0] days1_nxt;

  logic [16:0] secs2_r, secs2_nxt;
  logic [15:0] dnum2_r, dnum2_nxt;
  logic        after2_r, after2_nxt;
  logic [15:0] wx2_r, wx2_nxt;
  logic [13:0] wq2_r, wq2_nxt;

  logic [32:0] day_sec_prod;
  logic [31:0] secs_full;
  logic [15:0] dnum_raw;
  logic [32:0] wq_prod;

  // stage 1: whole days
  assign day_prod  = 51'(t[31:7]) * 51'(DAY_MUL);
  assign days1_nxt = day_prod[DAY_SHIFT +: 16];

  // stage 2: seconds of day, day number, weekday quotient
  assign day_sec_prod = 33'(days1_r) * 33'(SEC_PER_DAY);
  assign secs_full    = t1_r - day_sec_prod[31:0];
  assign secs2_nxt    = secs_full[16:0];
  assign dnum_raw     = days1_r + EPOCH_OFS;
  assign after2_nxt   = (dnum_raw >= LEAP_SKIP_DAY);
  assign dnum2_nxt    = dnum_raw + 16'(after2_nxt);
  assign wx2_nxt      = days1_r + WD_OFS;
  assign wq_prod      = 33'(wx2_nxt) * 33'(WD_MUL);
  assign wq2_nxt      = wq_prod[WD_SHIFT +: 14];

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      t1_r    <= t;
      days1_r <= days1_nxt;
    end
    if (ctl.load[1]) begin
      secs2_r  <= secs2_nxt;
      dnum2_r  <= dnum2_nxt;
      after2_r <= after2_nxt;
      wx2_r    <= wx2_nxt;
      wq2_r    <= wq2_nxt;
    end
  end

  assign secs       = secs2_r;
  assign dnum       = dnum2_r;
  assign after_skip = after2_r;
  assign wd_x       = wx2_r;
  assign wd_q       = wq2_r;

endmodule

`default_nettype wire

/* sv/esc_tod.sv */
`default_nettype none
`include "epoch_seconds_to_calendar_top_defines.svh"

module esc_tod
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire esc_ctl_t    ctl,
  input  wire logic [16:0] secs,
  output logic [4:0]       hour_of_day,
  output logic [5:0]       minute_of_hour,
  output logic [5:0]       second_of_minute
);

  logic [16:0] secs3_r;
  logic [4:0]  hour3_r, hour4_r, hour5_r, hour6_r, hour7_r;
  logic [11:0] rh4_r, rh5_r;
  logic [5:0]  min5_r, min6_r, min7_r;
  logic [5:0]  sec6_r, sec7_r;

  logic [26:0] hr_prod;
  logic [16:0] hs_prod;
  logic [16:0] rh_full;
  logic [20:0] mn_prod;
  logic [11:0] ms_prod;
  logic [11:0] sec_full;

  assign hr_prod  = 27'(secs[16:4]) * 27'(HR_MUL);
  assign hs_prod  = 17'(hour3_r) * 17'(SEC_PER_HR);
  assign rh_full  = secs3_r - hs_prod;
  assign mn_prod  = 21'(rh4_r[11:2]) * 21'(MIN_MUL);
  assign ms_prod  = 12'(min5_r) * SEC_PER_MIN;
  assign sec_full = rh5_r - ms_prod;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      secs3_r <= secs;
      hour3_r <= hr_prod[HR_SHIFT +: 5];
    end
    if (ctl.load[3]) begin
      hour4_r <= hour3_r;
      rh4_r   <= rh_full[11:0];
    end
    if (ctl.load[4]) begin
      hour5_r <= hour4_r;
      rh5_r   <= rh4_r;
      min5_r  <= mn_prod[MIN_SHIFT +: 6];
    end
    if (ctl.load[5]) begin
      hour6_r <= hour5_r;
      min6_r  <= min5_r;
      sec6_r  <= sec_full[5:0];
    end
    if (ctl.load[6]) begin
      hour7_r <= hour6_r;
      min7_r  <= min6_r;
      sec7_r  <= sec6_r;
    end
  end

  assign hour_of_day      = hour7_r;
  assign minute_of_hour   = min7_r;
  assign second_of_minute = sec7_r;

  `ESC_CHECK(a_tod_range, ctl.valid[6],
             hour7_r <= 5'd23 && min7_r <= 6'd59 && sec7_r <= 6'd59,
             "time of day out of range")

endmodule

`default_nettype wire

/* sv/esc_date.sv */
`default_nettype none
`include "epoch_seconds_to_calendar_top_defines.svh"

module esc_date
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire esc_ctl_t    ctl,
  input  wire logic [15:0] dnum,
  input  wire logic        after_skip,
  input  wire logic [15:0] wd_x,
  input  wire logic [13:0] wd_q,
  output logic [7:0]       years_since_1900,
  output logic [3:0]       month_index,
  output logic [4:0]       day_of_month,
  output logic [8:0]       day_of_year,
  output logic [2:0]       weekday
);

  logic [5:0]  c3_r, c4_r, c5_r;
  logic [15:0] dnum3_r;
  logic        after3_r, after4_r, after5_r;
  logic [2:0]  wd3_r, wd4_r, wd5_r, wd6_r, wd7_r;
  logic [10:0] r4_r;
  logic [1:0]  yc5_r;
  logic [8:0]  doy5_r, doy6_r, doy7_r;
  logic [7:0]  year6_r, year7_r;
  logic        leap6_r, fix6_r;
  logic [3:0]  month6_r, month7_r;
  logic [4:0]  mday7_r;

  logic [32:0] cy_prod;
  logic [16:0] wq7;
  logic [16:0] wd_full;
  logic [15:0] cd_prod;
  logic [15:0] r_full;
  logic [1:0]  yc_nxt;
  logic [10:0] yr_base;
  logic [10:0] doy_full;
  logic        leap_nxt;
  logic [3:0]  month_nxt;
  logic [8:0]  mday_full;

  // stage 3: four-year cycle index, weekday remainder
  assign cy_prod = 33'(dnum) * 33'(CYC_MUL);
  assign wq7     = {wd_q, 3'b000} - 17'(wd_q);
  assign wd_full = 17'(wd_x) - wq7;

  // stage 4: day within cycle
  assign cd_prod = 16'(c3_r) * 16'(CYC_DAYS);
  assign r_full  = dnum3_r - cd_prod;

  // stage 5: year within cycle, first year is leap
  always_comb begin
    if (r4_r < 11'd366) begin
      yc_nxt  = 2'd0;
      yr_base = 11'd0;
    end else if (r4_r < 11'd731) begin
      yc_nxt  = 2'd1;
      yr_base = 11'd366;
    end else if (r4_r < 11'd1096) begin
      yc_nxt  = 2'd2;
      yr_base = 11'd731;
    end else begin
      yc_nxt  = 2'd3;
      yr_base = 11'd1096;
    end
  end
  assign doy_full = r4_r - yr_base;

  // stage 6: month by comparing against month starts
  assign leap_nxt = (yc5_r == 2'd0);
  always_comb begin
    month_nxt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy5_r >= month_start(4'(k), leap_nxt)) begin
        month_nxt = month_nxt + 4'd1;
      end
    end
  end

  // stage 7: day of month
  assign mday_full = doy6_r - month_start(month6_r, leap6_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      c3_r     <= cy_prod[CYC_SHIFT +: 6];
      dnum3_r  <= dnum;
      after3_r <= after_skip;
      wd3_r    <= wd_full[2:0];
    end
    if (ctl.load[3]) begin
      c4_r     <= c3_r;
      r4_r     <= r_full[10:0];
      after4_r <= after3_r;
      wd4_r    <= wd3_r;
    end
    if (ctl.load[4]) begin
      c5_r     <= c4_r;
      yc5_r    <= yc_nxt;
      doy5_r   <= doy_full[8:0];
      after5_r <= after4_r;
      wd5_r    <= wd4_r;
    end
    if (ctl.load[5]) begin
      year6_r  <= YEAR_BASE + {c5_r, 2'b00} + 8'(yc5_r);
      leap6_r  <= leap_nxt;
      // phantom leap day of 2100 shifts its day of year after february
      fix6_r   <= after5_r && (c5_r == SKIP_CYCLE) && (yc5_r == 2'd0);
      month6_r <= month_nxt;
      doy6_r   <= doy5_r;
      wd6_r    <= wd5_r;
    end
    if (ctl.load[6]) begin
      year7_r  <= year6_r;
      month7_r <= month6_r;
      mday7_r  <= mday_full[4:0];
      doy7_r   <= doy6_r - 9'(fix6_r);
      wd7_r    <= wd6_r;
    end
  end

  assign years_since_1900 = year7_r;
  assign month_index      = month7_r;
  assign day_of_month     = mday7_r;
  assign day_of_year      = doy7_r;
  assign weekday          = wd7_r;

  `ESC_CHECK(a_date_range, ctl.valid[6],
             month7_r <= 4'd11 && mday7_r != 5'd0 && doy7_r <= 9'd365 && wd7_r <= 3'd6,
             "calendar date out of range")
  `ESC_CHECK(a_skip_after_feb, ctl.valid[5] && fix6_r, month6_r >= MONTH_MAR,
             "leap day correction before march")

endmodule

`default_nettype wire

/* sv/epoch_seconds_to_calendar_top.sv */
// unix seconds to broken-down gregorian calendar time
//
// in_* channel: one 32-bit unsigned count of seconds since 1970-01-01 00:00:00
// per transfer. out_* channel: one result per input, in input order, with
// year minus 1900, month, day of month, day of year, weekday, hour, minute
// and second.
//
// seven register stages; a result is offered on out_tvalid once it reaches the last
// stage. one transfer per cycle is sustained in both directions while the output
// side is not stalled.
//
// each stage holds one valid bit. a stage loads when it is empty or the stage
// after it moves, so bubbles close up and the input side keeps taking
// transfers while the last stage holds a result the receiver has not taken.
// once every stage is full and out_tready is low, in_tready drops and nothing
// moves; no data is lost or repeated.
//
// synchronous reset clears the valid bits only; the data registers are not reset.
`default_nettype none
`include "epoch_seconds_to_calendar_top_defines.svh"

module epoch_seconds_to_calendar_top
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] years_since_1900, [11:8] month_index, [16:12] day_of_month,
  // [25:17] day_of_year, [28:26] weekday, [33:29] hour_of_day,
  // [39:34] minute_of_hour, [45:40] second_of_minute, [47:46] zero
  output logic [47:0]      out_tdata
);

  logic [NUM_STG-1:0] vld_r, vld_nxt;
  logic [NUM_STG-1:0] rdy;
  esc_ctl_t           ctl;

  // split results at stage 2
  logic [16:0] secs;
  logic [15:0] dnum;
  logic        after_skip;
  logic [15:0] wd_x;
  logic [13:0] wd_q;

  logic [7:0] years_since_1900;
  logic [3:0] month_index;
  logic [4:0] day_of_month;
  logic [8:0] day_of_year;
  logic [2:0] weekday;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;

  // a stage can load when empty or when its content moves on
  always_comb begin
    rdy[NUM_STG-1] = !vld_r[NUM_STG-1] || out_tready;
    for (int i = NUM_STG - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = rdy[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < NUM_STG; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.load  = rdy;
  assign ctl.valid = vld_r;

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NUM_STG-1];

  // stages 1-2: days, seconds of day, day number, weekday quotient
  esc_split u_split (
    .clk        (clk),
    .ctl        (ctl),
    .t          (in_tdata),
    .secs       (secs),
    .dnum       (dnum),
    .after_skip (after_skip),
    .wd_x       (wd_x),
    .wd_q       (wd_q)
  );

  // stages 3-7: hour, minute, second
  esc_tod u_tod (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .secs             (secs),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute)
  );

  // stages 3-7: year, month, day, weekday
  esc_date u_date (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .dnum             (dnum),
    .after_skip       (after_skip),
    .wd_x             (wd_x),
    .wd_q             (wd_q),
    .years_since_1900 (years_since_1900),
    .month_index      (month_index),
    .day_of_month     (day_of_month),
    .day_of_year      (day_of_year),
    .weekday          (weekday)
  );

  assign out_tdata = {2'b00, second_of_minute, minute_of_hour, hour_of_day, weekday,
                      day_of_year, day_of_month, month_index, years_since_1900};

  `ESC_CHECK(a_ready_when_drained, out_tready, in_tready,
             "input stalled while output side is ready")
  `ESC_CHECK_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0],
                  "accepted transfer did not enter the first stage")

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`default_nettype none

module tb_top;

  // one broken-down calendar time, laid out as out_tdata carries it
  // (last field in the lowest bits, two zero bits on top)
  typedef struct packed {
    logic [1:0] pad;
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [2:0] weekday;
    logic [8:0] day_of_year;
    logic [4:0] day_of_month;
    logic [3:0] month_index;
    logic [7:0] years_since_1900;
  } calendar_t;

  localparam int unsigned SECS_IN_DAY   = 86400;
  // day number of 1970-01-01 when 0001-01-01 is day 1
  localparam int unsigned EPOCH_DAY_NUM = 719163;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned DRAIN_CYCLES  = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;     // [31:0] epoch_seconds
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] years_since_1900, [11:8] month_index, [16:12] day_of_month,
  // [25:17] day_of_year, [28:26] weekday, [33:29] hour_of_day,
  // [39:34] minute_of_hour, [45:40] second_of_minute, [47:46] zero
  logic [47:0] out_tdata;

  calendar_t pending_dates[$];    // predicted results, oldest first
  int        error_count = 0;
  bit        steady_flow = 1'b0;  // no idle cycles on either side
  bit        hold_request = 1'b0; // ask the receiver for a long hold-off

  epoch_seconds_to_calendar_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------
  // calendar arithmetic
  // ---------------------------------------------------------------

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // days in years 1..y inclusive
  function automatic int unsigned days_thru_year(input int unsigned y);
    return y * 365 + y / 4 - y / 100 + y / 400;
  endfunction

  // civil time of an unsigned unix timestamp
  function automatic calendar_t civil_from_seconds(input logic [31:0] t);
    int unsigned    days, secs, day_num, year, day_in_year, shifted, month, mday;
    longint unsigned estimate;
    calendar_t      r;
    days     = t / SECS_IN_DAY;
    secs     = t % SECS_IN_DAY;
    day_num  = days + EPOCH_DAY_NUM;
    // year estimate from the 400-year cycle length, then step it up
    estimate = (longint'(day_num) * 400) / 146097;
    year     = int'(estimate);
    while (days_thru_year(year) < day_num) year++;
    day_in_year = day_num - days_thru_year(year - 1);   // 1..366
    // treat february as 30 days so one linear formula fits all months
    shifted = day_in_year;
    if (shifted > 59) begin
      shifted += 2;
      if (is_leap(year)) shifted -= (shifted > 62) ? 1 : 2;
    end
    month = (shifted * 100 + 3007) / 3057;              // 1..12
    mday  = shifted - (month * 3057 - 3007) / 100;
    r.pad              = '0;
    r.years_since_1900 = 8'(year - 1900);
    r.month_index      = 4'(month - 1);
    r.day_of_month     = 5'(mday);
    r.day_of_year      = 9'(day_in_year - 1);
    r.weekday          = 3'((days + 4) % 7);
    r.hour_of_day      = 5'(secs / 3600);
    r.minute_of_hour   = 6'((secs / 60) % 60);
    r.second_of_minute = 6'(secs % 60);
    return r;
  endfunction

  // ---------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // values seen here are the ones from just before the edge
  always @(posedge clk) begin
    calendar_t exp_date, got_date;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_date = calendar_t'(out_tdata);
        if (pending_dates.size() == 0) begin
          $error("result transfer with no prediction waiting: %h", out_tdata);
          error_count++;
        end else begin
          exp_date = pending_dates.pop_front();
          check_field("years_since_1900", exp_date.years_since_1900,
                      got_date.years_since_1900);
          check_field("month_index", exp_date.month_index, got_date.month_index);
          check_field("day_of_month", exp_date.day_of_month, got_date.day_of_month);
          check_field("day_of_year", exp_date.day_of_year, got_date.day_of_year);
          check_field("weekday", exp_date.weekday, got_date.weekday);
          check_field("hour_of_day", exp_date.hour_of_day, got_date.hour_of_day);
          check_field("minute_of_hour", exp_date.minute_of_hour,
                      got_date.minute_of_hour);
          check_field("second_of_minute", exp_date.second_of_minute,
                      got_date.second_of_minute);
          check_field("pad", exp_date.pad, got_date.pad);
        end
      end
      // every accepted timestamp gets its prediction queued
      if (in_tvalid && in_tready) pending_dates.push_back(civil_from_seconds(in_tdata));
    end
  end

  // ---------------------------------------------------------------
  // receiver: random stall before each result, long hold-off on request
  // ---------------------------------------------------------------

  initial begin
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        // keep out_tready low long enough for the pipeline to fill
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = steady_flow ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      // wait for the result transfer
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ---------------------------------------------------------------
  // sender: one timestamp per call, random gap before it
  // ---------------------------------------------------------------

  task automatic send_seconds(input logic [31:0] t);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    // wait for the input transfer
    do @(posedge clk); while (!in_tready);
  endtask

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------

  // ends of the input range and first day boundaries
  task automatic test_extremes();
    send_seconds(32'd0);
    send_seconds(32'd1);
    send_seconds(32'd86399);
    send_seconds(32'd86400);
    send_seconds(32'h7FFF_FFFF);
    send_seconds(32'h8000_0000);
    send_seconds(32'hFFFF_FFFE);
    send_seconds(32'hFFFF_FFFF);    // 2106-02-07 06:28:15
  endtask

  // feb 28 / feb 29 / mar 1 across leap and non-leap years, last day of leap year
  task automatic test_leap_days();
    send_seconds(32'd951696000);    // 2000-02-28, leap by the 400 rule
    send_seconds(32'd951782400);    // 2000-02-29
    send_seconds(32'd951868800);    // 2000-03-01
    send_seconds(32'd4107456000);   // 2100-02-28, century without leap day
    send_seconds(32'd4107542400);   // 2100-03-01
    send_seconds(32'd4233686400);   // 2104-02-29
    send_seconds(32'd94608000);     // 1972-12-31, day of year 365
    send_seconds(32'd978307199);    // 2000-12-31 23:59:59
  endtask

  // hour and minute rollovers within one day
  task automatic test_time_of_day();
    logic [31:0] midnight;
    midnight = 32'd20000 * SECS_IN_DAY;
    send_seconds(midnight + 32'd59);
    send_seconds(midnight + 32'd60);
    send_seconds(midnight + 32'd3599);
    send_seconds(midnight + 32'd3600);
    send_seconds(midnight + 32'd43199);
  endtask

  // mix of raw 32-bit values, day boundaries and both ends of the range
  task automatic test_random_times(input int unsigned count);
    longint unsigned stamp;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: stamp = $urandom;
        1: begin
          stamp = longint'($urandom_range(0, 49710)) * SECS_IN_DAY;
          case ($urandom_range(0, 2))
            0: stamp += 0;
            1: stamp += SECS_IN_DAY - 1;
            default: stamp += $urandom_range(0, SECS_IN_DAY - 1);
          endcase
          if (stamp > 64'hFFFF_FFFF) stamp = $urandom;
        end
        2: stamp = $urandom_range(0, 1 << 22);
        default: stamp = 32'hFFFF_FFFF - $urandom_range(0, 1 << 24);
      endcase
      send_seconds(stamp[31:0]);
    end
  endtask

  // back-to-back traffic on both sides
  task automatic test_full_rate();
    steady_flow = 1'b1;
    test_random_times(60);
    steady_flow = 1'b0;
  endtask

  // receiver holds off while inputs keep coming, so in_tready must drop
  task automatic test_backpressure();
    hold_request = 1'b1;
    steady_flow  = 1'b1;
    test_random_times(40);
    steady_flow  = 1'b0;
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_leap_days();
    test_time_of_day();
    test_random_times(200);
    test_full_rate();
    test_backpressure();
    test_random_times(230);

    in_tvalid <= 1'b0;
    // drain the pipeline, then give stray results a chance to show up
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
